// ===== design/sdr_pkg.sv =====
// Shared types, codes and CRC helpers for the SD SPI command and block reader.
`default_nettype none

package sdr_pkg;

  localparam int MAX_RESULTS = 7;
  localparam int CNT_W       = 3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_TX     = 2'd0;
  localparam kind_t KIND_RX     = 2'd1;
  localparam kind_t KIND_STATUS = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_NO_RESP  = 3'd1;
  localparam status_t ST_R1_ERR   = 3'd2;
  localparam status_t ST_TIMEOUT  = 3'd3;
  localparam status_t ST_CRC_BAD  = 3'd4;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_RESPONSE_RETRIES = 1'd0;
  localparam reg_idx_t REG_TOKEN_TIMEOUT    = 1'd1;

  localparam logic [7:0] BYTE_IDLE    = 8'hFF;
  localparam logic [7:0] CMD_START    = 8'h40;
  localparam logic [7:0] DATA_TOKEN   = 8'hFE;
  localparam logic [7:0] R1_ERR_MASK  = 8'h7E;
  localparam logic [6:0] CRC7_POLY    = 7'h09;
  localparam logic [15:0] CRC16_POLY  = 16'h1021;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_SKIP  = 8'b0000_0010,
    PH_R1    = 8'b0000_0100,
    PH_EXTRA = 8'b0000_1000,
    PH_TOKEN = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CRCHI = 8'b0100_0000,
    PH_CRCLO = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic        check_errors;
    logic [2:0]  extra_bytes;
    logic [9:0]  data_bytes;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    status_t     status;
    logic [7:0]  r1_value;
    logic        last;
  } result_t;

  function automatic result_t mk_result(kind_t k, logic [7:0] v, status_t st,
                                        logic [7:0] r1, logic lst);
    result_t r;
    r.kind       = k;
    r.byte_value = v;
    r.status     = st;
    r.r1_value   = r1;
    r.last       = lst;
    return r;
  endfunction

  // msb-first CRC7 over one byte
  function automatic logic [6:0] crc7_byte(logic [6:0] crc_in, logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0};
      if (fb) c = c ^ CRC7_POLY;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC16_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sdr_ifs.sv =====
// Valid/ready channel interfaces: command and byte input, result output, register writes.
`default_nettype none

interface sdr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  command_index;
  logic [31:0] argument;
  logic        check_errors;
  logic [2:0]  extra_bytes;
  logic [9:0]  data_bytes;
  logic [15:0] block_count;
  logic [7:0]  rx_byte;
  modport source (output valid, cmd, command_index, argument, check_errors,
                  extra_bytes, data_bytes, block_count, rx_byte, input ready);
  modport sink   (input valid, cmd, command_index, argument, check_errors,
                  extra_bytes, data_bytes, block_count, rx_byte, output ready);
endinterface

interface sdr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [2:0] status;
  logic [7:0] r1_value;
  logic       last;
  modport source (output valid, kind, byte_value, status, r1_value, last, input ready);
  modport sink   (input valid, kind, byte_value, status, r1_value, last, output ready);
endinterface

interface sdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [21:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/sdr_engine.sv =====
// Protocol state and per-item result generation for the SD SPI reader.
`default_nettype none

module sdr_engine
  import sdr_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire item_t       item,
  input  wire logic [3:0]  response_retries,
  input  wire logic [21:0] token_timeout,
  output result_t          res [MAX_RESULTS],
  output logic [CNT_W-1:0] res_count
);

  phase_t      phase, phase_next;
  logic [21:0] retry_count, retry_count_next;
  logic [9:0]  byte_count, byte_count_next;
  logic [15:0] blocks_left, blocks_left_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  crc_high, crc_high_next;
  logic [7:0]  r1_hold, r1_hold_next;
  logic        req_check, req_check_next;
  logic [2:0]  req_extra, req_extra_next;
  logic [9:0]  req_data, req_data_next;

  logic [7:0]  rx;
  logic [21:0] retry_inc;
  logic [9:0]  byte_inc;
  logic [21:0] lim_resp, lim_tok;
  logic [6:0]  c7;
  logic [7:0]  frame [MAX_RESULTS];
  logic        no_data;

  always_comb begin
    rx        = item.rx_byte;
    retry_inc = retry_count + 22'd1;
    byte_inc  = byte_count + 10'd1;
    lim_resp  = (response_retries == 4'd0) ? 22'd1 : {18'd0, response_retries};
    lim_tok   = (token_timeout == 22'd0) ? 22'd1 : token_timeout;
    no_data   = (req_data == 10'd0) || (blocks_left == 16'd0);

    frame[0] = BYTE_IDLE;
    frame[1] = CMD_START | {2'b00, item.command_index};
    frame[2] = item.argument[31:24];
    frame[3] = item.argument[23:16];
    frame[4] = item.argument[15:8];
    frame[5] = item.argument[7:0];
    c7 = 7'd0;
    for (int i = 1; i <= 5; i++) c7 = crc7_byte(c7, frame[i]);
    frame[6] = {c7, 1'b1};

    phase_next       = phase;
    retry_count_next = retry_count;
    byte_count_next  = byte_count;
    blocks_left_next = blocks_left;
    crc_acc_next     = crc_acc;
    crc_high_next    = crc_high;
    r1_hold_next     = r1_hold;
    req_check_next   = req_check;
    req_extra_next   = req_extra;
    req_data_next    = req_data;
    for (int i = 0; i < MAX_RESULTS; i++)
      res[i] = mk_result(KIND_TX, 8'h00, ST_OK, BYTE_IDLE, 1'b0);
    res_count = '0;

    if (!item.cmd) begin
      for (int i = 0; i < MAX_RESULTS; i++)
        res[i] = mk_result(KIND_TX, frame[i], ST_OK, BYTE_IDLE, i == MAX_RESULTS - 1);
      res_count      = CNT_W'(MAX_RESULTS);
      req_check_next = item.check_errors;
      req_extra_next = item.extra_bytes;
      if (32'(item.data_bytes) > MAX_BLOCK_BYTES) req_data_next = 10'(MAX_BLOCK_BYTES);
      else                                        req_data_next = item.data_bytes;
      blocks_left_next = item.block_count;
      r1_hold_next     = BYTE_IDLE;
      retry_count_next = '0;
      byte_count_next  = '0;
      crc_acc_next     = '0;
      crc_high_next    = '0;
      phase_next       = PH_SKIP;
    end else begin
      unique case (phase)
        PH_SKIP: begin
          phase_next       = PH_R1;
          retry_count_next = '0;
        end
        PH_R1: begin
          r1_hold_next     = rx;
          retry_count_next = retry_inc;
          if (!rx[7]) begin
            if (req_check && ((rx & R1_ERR_MASK) != 8'h00)) begin
              res[0]     = mk_result(KIND_STATUS, 8'h00, ST_R1_ERR, rx, 1'b1);
              res_count  = CNT_W'(1);
              phase_next = PH_IDLE;
            end else if (req_extra != 3'd0) begin
              phase_next      = PH_EXTRA;
              byte_count_next = '0;
            end else if (no_data) begin
              res[0]     = mk_result(KIND_STATUS, 8'h00, ST_OK, rx, 1'b1);
              res_count  = CNT_W'(1);
              phase_next = PH_IDLE;
            end else begin
              phase_next       = PH_TOKEN;
              retry_count_next = '0;
            end
          end else if (retry_inc >= lim_resp) begin
            res[0]     = mk_result(KIND_STATUS, 8'h00, ST_NO_RESP, rx, 1'b1);
            res_count  = CNT_W'(1);
            phase_next = PH_IDLE;
          end
        end
        PH_EXTRA: begin
          res[0]          = mk_result(KIND_RX, rx, ST_OK, r1_hold, 1'b0);
          res_count       = CNT_W'(1);
          byte_count_next = byte_inc;
          if (byte_inc >= {7'd0, req_extra}) begin
            if (no_data) begin
              res[1]     = mk_result(KIND_STATUS, 8'h00, ST_OK, r1_hold, 1'b1);
              res_count  = CNT_W'(2);
              phase_next = PH_IDLE;
            end else begin
              phase_next       = PH_TOKEN;
              retry_count_next = '0;
            end
          end
        end
        PH_TOKEN: begin
          retry_count_next = retry_inc;
          if (rx == DATA_TOKEN) begin
            phase_next      = PH_DATA;
            byte_count_next = '0;
            crc_acc_next    = '0;
          end else if (retry_inc >= lim_tok) begin
            res[0]     = mk_result(KIND_STATUS, 8'h00, ST_TIMEOUT, r1_hold, 1'b1);
            res_count  = CNT_W'(1);
            phase_next = PH_IDLE;
          end
        end
        PH_DATA: begin
          res[0]          = mk_result(KIND_RX, rx, ST_OK, r1_hold, 1'b0);
          res_count       = CNT_W'(1);
          crc_acc_next    = crc16_byte(crc_acc, rx);
          byte_count_next = byte_inc;
          if (byte_inc >= req_data) phase_next = PH_CRCHI;
        end
        PH_CRCHI: begin
          crc_high_next = rx;
          phase_next    = PH_CRCLO;
        end
        PH_CRCLO: begin
          if ({crc_high, rx} != crc_acc) begin
            res[0]     = mk_result(KIND_STATUS, 8'h00, ST_CRC_BAD, r1_hold, 1'b1);
            res_count  = CNT_W'(1);
            phase_next = PH_IDLE;
          end else begin
            blocks_left_next = blocks_left - 16'd1;
            if (blocks_left == 16'd1) begin
              res[0]     = mk_result(KIND_STATUS, 8'h00, ST_OK, r1_hold, 1'b1);
              res_count  = CNT_W'(1);
              phase_next = PH_IDLE;
            end else begin
              phase_next       = PH_TOKEN;
              retry_count_next = '0;
            end
          end
        end
        PH_IDLE: begin
          // stray byte with no command running
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      retry_count <= '0;
      byte_count  <= '0;
      blocks_left <= '0;
      crc_acc     <= '0;
      crc_high    <= '0;
      r1_hold     <= BYTE_IDLE;
      req_check   <= 1'b0;
      req_extra   <= '0;
      req_data    <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      retry_count <= retry_count_next;
      byte_count  <= byte_count_next;
      blocks_left <= blocks_left_next;
      crc_acc     <= crc_acc_next;
      crc_high    <= crc_high_next;
      r1_hold     <= r1_hold_next;
      req_check   <= req_check_next;
      req_extra   <= req_extra_next;
      req_data    <= req_data_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/sd_spi_command_and_block_reader.sv =====
// SD card SPI-mode host engine: command framing, R1 hunt and block read with CRC16 check.
//
// Channels: req carries either a command (cmd = 0) or one byte received from the card
// (cmd = 1); rsp carries transmit bytes, received payload/trailing bytes and one final
// status per command; cfg writes response_retries (index 0) and token_timeout (index 1)
// and is always ready.
// A req beat is registered, then processed into a result buffer of up to seven entries;
// rsp shows the buffer head, so each result passes the input register and the result
// buffer before it appears. rsp drains one result per cycle while rsp.ready is high.
// A command yields seven rsp beats and occupies the result buffer until its last beat
// leaves. A received byte yields at most two results and, with rsp ready, one
// received byte is taken per cycle; a byte that yields both a payload byte and a status
// holds the next byte until the status leaves the buffer. Throughput is set by the rsp drain rate.
// If rsp stalls, the buffer holds and one further req beat waits in the input
// register before req.ready drops.
// Reset clears the buffer and the protocol state and loads response_retries = 8 and
// token_timeout = 3000000; no clearing pass is needed.
`default_nettype none

module sd_spi_command_and_block_reader
  import sdr_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = 512
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sdr_in_if.sink     req,
  sdr_out_if.source  rsp,
  sdr_cfg_if.sink    cfg
);

  logic [3:0]  response_retries;
  logic [21:0] token_timeout;

  item_t            in_q;
  logic             in_q_valid;
  result_t          rbuf [MAX_RESULTS];
  logic [CNT_W-1:0] rcnt;
  result_t          res [MAX_RESULTS];
  logic [CNT_W-1:0] res_count;
  logic             out_fire, room, proc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_retries <= 4'd8;
      token_timeout    <= 22'd3000000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RESPONSE_RETRIES: response_retries <= cfg.data[3:0];
        REG_TOKEN_TIMEOUT:    token_timeout    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign out_fire  = rsp.valid && rsp.ready;
  // buffer free when empty or once its last entry leaves this cycle
  assign room      = (rcnt == '0) || ((rcnt == CNT_W'(1)) && out_fire);
  assign proc      = in_q_valid && room;
  assign req.ready = !in_q_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (req.ready) begin
      in_q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_q.cmd           <= req.cmd;
      in_q.command_index <= req.command_index;
      in_q.argument      <= req.argument;
      in_q.check_errors  <= req.check_errors;
      in_q.extra_bytes   <= req.extra_bytes;
      in_q.data_bytes    <= req.data_bytes;
      in_q.block_count   <= req.block_count;
      in_q.rx_byte       <= req.rx_byte;
    end
  end

  sdr_engine #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .fire             (proc),
    .item             (in_q),
    .response_retries (response_retries),
    .token_timeout    (token_timeout),
    .res              (res),
    .res_count        (res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
    end else if (proc) begin
      rcnt <= res_count;
    end else if (out_fire) begin
      rcnt <= rcnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < MAX_RESULTS; i++) rbuf[i] <= res[i];
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) rbuf[i] <= rbuf[i+1];
    end
  end

  assign rsp.valid      = (rcnt != '0);
  assign rsp.kind       = rbuf[0].kind;
  assign rsp.byte_value = rbuf[0].byte_value;
  assign rsp.status     = rbuf[0].status;
  assign rsp.r1_value   = rbuf[0].r1_value;
  assign rsp.last       = rbuf[0].last;

endmodule

`default_nettype wire
